>>> hw/rtl/ps2md_pkg.sv
// ps2md_pkg: shared types and constants for the ps/2 mouse packet decoder
// used by ps2md_fmt and ps2_mouse_packet_decoder; no dependencies
package ps2md_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BTN_W      = 3;
  localparam int unsigned DX_W       = 9;
  localparam int unsigned DY_W       = 10;
  localparam int unsigned OUT_DATA_W = 40;

  // header byte bits
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned XSIGN_BIT  = 4;
  localparam int unsigned YSIGN_BIT  = 5;
  localparam int unsigned BTN_FIRST  = 0;
  localparam int unsigned BTN_THIRD  = 1;
  localparam int unsigned BTN_SECOND = 2;

  typedef enum logic [1:0] {
    POS_B0 = 2'd0,
    POS_B1 = 2'd1,
    POS_B2 = 2'd2,
    POS_B3 = 2'd3
  } pos_t;

  // packed lowest field last so moved sits in bit 0
  typedef struct packed {
    logic signed [BYTE_W-1:0] scroll_delta;
    logic                     scroll_valid;
    logic [BTN_W-1:0]         buttons_changed;
    logic [BTN_W-1:0]         buttons;
    logic signed [DY_W-1:0]   delta_y;
    logic signed [DX_W-1:0]   delta_x;
    logic                     moved;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

>>> hw/rtl/ps2md_fmt.sv
// ps2md_fmt: turns the assembled packet bytes into one decoded result
// depends on ps2md_pkg
module ps2md_fmt (
  input  logic [ps2md_pkg::BYTE_W-1:0] b0,
  input  logic [ps2md_pkg::BYTE_W-1:0] b1,
  input  logic [ps2md_pkg::BYTE_W-1:0] b2,
  input  logic [ps2md_pkg::BYTE_W-1:0] b3,
  input  logic                         wheel,
  input  logic [ps2md_pkg::BTN_W-1:0]  btn_state,
  output ps2md_pkg::result_t           res
);

  logic                             moved;
  logic [ps2md_pkg::BTN_W-1:0]      btn;
  logic signed [ps2md_pkg::DY_W-1:0] y_ext;
  logic                             sv;

  assign moved = (b1 != '0) || (b2 != '0);
  assign btn   = {b0[ps2md_pkg::BTN_THIRD], b0[ps2md_pkg::BTN_SECOND],
                  b0[ps2md_pkg::BTN_FIRST]};
  // y byte sign-extended by its sign bit, negated below
  assign y_ext = {b0[ps2md_pkg::YSIGN_BIT], b0[ps2md_pkg::YSIGN_BIT], b2};
  assign sv    = wheel && (b3 != '0);

  always_comb begin
    res.moved           = moved;
    res.delta_x         = moved ? {b0[ps2md_pkg::XSIGN_BIT], b1} : '0;
    res.delta_y         = moved ? -y_ext : '0;
    res.buttons         = btn;
    res.buttons_changed = btn ^ btn_state;
    res.scroll_valid    = sv;
    res.scroll_delta    = sv ? b3 : '0;
  end

endmodule

>>> hw/rtl/ps2_mouse_packet_decoder.sv
// ps2_mouse_packet_decoder: assembles 3- or 4-byte ps/2 mouse packets
// path: input register, then result register; the byte position and button registers
// are the only loops; throughput one byte per cycle while the output is not stalled
// reset: rst_n synchronous active low; clears position, buttons, wheel mode, valids
// depends on ps2md_pkg and ps2md_fmt
module ps2_mouse_packet_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ps2md_pkg::BYTE_W-1:0]          in_tdata,  // [7:0] rx_byte
  input  logic                                  in_tuser,  // [0] abort
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] moved, [9:1] delta_x, [19:10] delta_y, [22:20] buttons,
  // [25:23] buttons_changed, [26] scroll_valid, [34:27] scroll_delta, rest zero
  output logic [ps2md_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_data   // wheel_mode
);

  logic                          wheel_r;
  logic                          s0_valid_r;
  logic [ps2md_pkg::BYTE_W-1:0]  s0_byte_r;
  logic                          s0_abort_r;
  ps2md_pkg::pos_t               pos_r, pos_nxt;
  logic [ps2md_pkg::BYTE_W-1:0]  b0_r, b1_r, b2_r;
  logic [ps2md_pkg::BTN_W-1:0]   btn_r;
  logic                          out_valid_r;
  ps2md_pkg::result_t            out_data_r;

  logic                          out_free;
  logic                          adv;
  logic                          emit;
  logic                          bad_first;
  logic [ps2md_pkg::BYTE_W-1:0]  fmt_b2;
  logic                          fmt_wheel;
  ps2md_pkg::result_t            fmt_res;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign adv        = s0_valid_r && out_free;
  assign in_tready  = !s0_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ps2md_pkg::OUT_DATA_W - ps2md_pkg::RESULT_W){1'b0}}, out_data_r};

  // header must carry the sync bit and no overflow bits
  assign bad_first = !s0_byte_r[ps2md_pkg::SYNC_BIT] || (s0_byte_r[7:6] != 2'b00);

  always_comb begin
    pos_nxt = pos_r;
    emit    = 1'b0;
    if (s0_abort_r) begin
      pos_nxt = ps2md_pkg::POS_B0;
    end else begin
      case (pos_r)
        ps2md_pkg::POS_B0: begin
          if (!bad_first) pos_nxt = ps2md_pkg::POS_B1;
        end
        ps2md_pkg::POS_B1: pos_nxt = ps2md_pkg::POS_B2;
        ps2md_pkg::POS_B2: begin
          if (wheel_r) begin
            pos_nxt = ps2md_pkg::POS_B3;
          end else begin
            pos_nxt = ps2md_pkg::POS_B0;
            emit    = 1'b1;
          end
        end
        ps2md_pkg::POS_B3: begin
          pos_nxt = ps2md_pkg::POS_B0;
          emit    = 1'b1;
        end
        default: pos_nxt = ps2md_pkg::POS_B0;
      endcase
    end
  end

  // wheel cleared mid-packet: the fourth beat stands in for byte 2
  assign fmt_wheel = (pos_r == ps2md_pkg::POS_B3) && wheel_r;
  assign fmt_b2    = fmt_wheel ? b2_r : s0_byte_r;

  ps2md_fmt u_fmt (
    .b0        (b0_r),
    .b1        (b1_r),
    .b2        (fmt_b2),
    .b3        (s0_byte_r),
    .wheel     (fmt_wheel),
    .btn_state (btn_r),
    .res       (fmt_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_r     <= 1'b0;
      s0_valid_r  <= 1'b0;
      pos_r       <= ps2md_pkg::POS_B0;
      btn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) wheel_r <= cfg_data;
      if (in_tready) s0_valid_r <= in_tvalid;
      if (adv) begin
        pos_r <= pos_nxt;
        if (emit) btn_r <= fmt_res.buttons;
      end
      if (out_free) out_valid_r <= adv && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_byte_r  <= in_tdata;
      s0_abort_r <= in_tuser;
    end
    if (adv && !s0_abort_r) begin
      case (pos_r)
        ps2md_pkg::POS_B0: if (!bad_first) b0_r <= s0_byte_r;
        ps2md_pkg::POS_B1: b1_r <= s0_byte_r;
        ps2md_pkg::POS_B2: b2_r <= s0_byte_r;
        ps2md_pkg::POS_B3: if (!wheel_r) b2_r <= s0_byte_r;
        default: ;
      endcase
    end
    if (adv && emit) out_data_r <= fmt_res;
  end

`ifndef SYNTHESIS
  a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit |-> (pos_r == ps2md_pkg::POS_B2 || pos_r == ps2md_pkg::POS_B3))
    else $error("result from a partial packet");

  a_abort_pos: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s0_abort_r |=> pos_r == ps2md_pkg::POS_B0)
    else $error("abort did not restart the packet");

  a_btn_track: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit |=> btn_r == out_data_r.buttons)
    else $error("stored buttons differ from delivered buttons");

  a_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.moved |-> out_data_r.delta_x == '0 && out_data_r.delta_y == '0)
    else $error("motion reported without a nonzero motion byte");
`endif

endmodule
